FILE: rtl/core/sparse_csr_to_dia_converter_assert.svh
// Assertion macros used by the CSR to DIA converter top level.
`ifndef SPARSE_CSR_TO_DIA_CONVERTER_ASSERT_SVH
`define SPARSE_CSR_TO_DIA_CONVERTER_ASSERT_SVH
`ifndef SYNTHESIS
`define CSR2DIA_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);
`define CSR2DIA_ASSERT_NEVER(name, cond, msg) \
  `CSR2DIA_ASSERT(name, !(cond), msg)
`else
`define CSR2DIA_ASSERT(name, prop, msg)
`define CSR2DIA_ASSERT_NEVER(name, cond, msg)
`endif
`endif

FILE: rtl/core/csr2dia_pkg.sv
// Shared types, codes and widths of the CSR to DIA converter.
package csr2dia_pkg;

  localparam int unsigned MAX_SIZE_DEF = 32;

  localparam int unsigned CFG_W    = 6;
  localparam int unsigned FUNC_W   = 2;
  localparam int unsigned IDX_W    = 5;
  localparam int unsigned WORD_W   = 64;
  localparam int unsigned RANK_W   = 6;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned COUNT_W  = 6;
  localparam int unsigned OFFSET_W = 6;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_CLEAR  = 2'd0,
    FUNC_INSERT = 2'd1,
    FUNC_FINISH = 2'd2,
    FUNC_READ   = 2'd3
  } func_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_RANGE = 2'd1,
    STAT_ORDER = 2'd2
  } status_t;

  typedef struct packed {
    logic [WORD_W-1:0] xx;
    logic [WORD_W-1:0] yy;
    logic [WORD_W-1:0] zz;
  } words_t;

  typedef struct packed {
    logic   vld;
    words_t w;
  } entry_t;

  typedef struct packed {
    logic wr_en;
    logic wr_valid;
    logic rd_en;
  } slot_ctl_t;

  typedef struct packed {
    logic clr;
    logic mark;
    logic walk;
    logic rd_en;
  } rank_ctl_t;

  typedef struct packed {
    logic walking;
    logic ranked;
  } rank_sts_t;

endpackage

FILE: rtl/core/csr2dia_slot_mem.sv
// Slot store: one synchronous memory holding a valid bit and three words per slot.
module csr2dia_slot_mem #(
  parameter int unsigned MAX_SIZE = csr2dia_pkg::MAX_SIZE_DEF,
  localparam int unsigned DIAG_W = $clog2(2 * MAX_SIZE - 1),
  localparam int unsigned ROW_W  = $clog2(MAX_SIZE),
  localparam int unsigned ADDR_W = DIAG_W + ROW_W
) (
  input  logic                  clk,
  input  csr2dia_pkg::slot_ctl_t ctl,
  input  logic [ADDR_W-1:0]     addr,
  input  csr2dia_pkg::words_t   wr_words,
  output logic                  rd_vld,
  output csr2dia_pkg::words_t   rd_words
);
  import csr2dia_pkg::*;

  localparam int unsigned DEPTH = (2 * MAX_SIZE - 1) << ROW_W;

  entry_t mem [DEPTH];
  entry_t rd_q_r;

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[addr] <= '{vld: ctl.wr_valid, w: wr_words};
    end
    if (ctl.rd_en) begin
      rd_q_r <= mem[addr];
    end
  end

  assign rd_vld   = rd_q_r.vld;
  assign rd_words = rd_q_r.w;

endmodule

FILE: rtl/core/csr2dia_rank_unit.sv
// Diagonal presence flags, ranking walk and rank table memory.
module csr2dia_rank_unit #(
  parameter int unsigned MAX_SIZE = csr2dia_pkg::MAX_SIZE_DEF,
  localparam int unsigned DIAG_W = $clog2(2 * MAX_SIZE - 1),
  localparam int unsigned CNT_W  = $clog2(2 * MAX_SIZE)
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  csr2dia_pkg::rank_ctl_t ctl,
  input  logic [DIAG_W-1:0]      mark_diag,
  input  logic [DIAG_W-1:0]      rd_idx,
  output csr2dia_pkg::rank_sts_t sts,
  output logic [CNT_W-1:0]       total,
  output logic [DIAG_W-1:0]      rd_diag
);
  import csr2dia_pkg::*;

  localparam int unsigned NDIAG = 2 * MAX_SIZE - 1;
  localparam logic [DIAG_W-1:0] LAST_DIAG = DIAG_W'(NDIAG - 1);

  logic [NDIAG-1:0]  present_r;
  logic [DIAG_W-1:0] rank_mem [NDIAG];
  logic [DIAG_W-1:0] walk_diag_r;
  logic [CNT_W-1:0]  fill_r;
  logic [CNT_W-1:0]  fill_nxt;
  logic [CNT_W-1:0]  total_r;
  logic              walking_r;
  logic              ranked_r;
  logic [DIAG_W-1:0] rd_diag_r;
  logic              hit;

  assign hit      = present_r[walk_diag_r];
  assign fill_nxt = fill_r + CNT_W'(hit);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      present_r   <= '0;
      walk_diag_r <= '0;
      fill_r      <= '0;
      total_r     <= '0;
      walking_r   <= 1'b0;
      ranked_r    <= 1'b0;
    end else begin
      if (ctl.clr) begin
        present_r <= '0;
        total_r   <= '0;
        ranked_r  <= 1'b0;
      end
      if (ctl.mark) begin
        present_r[mark_diag] <= 1'b1;
        ranked_r             <= 1'b0;
      end
      if (ctl.walk) begin
        walking_r   <= 1'b1;
        walk_diag_r <= '0;
        fill_r      <= '0;
      end else if (walking_r) begin
        walk_diag_r <= walk_diag_r + 1'b1;
        fill_r      <= fill_nxt;
        if (walk_diag_r == LAST_DIAG) begin
          walking_r <= 1'b0;
          total_r   <= fill_nxt;
          ranked_r  <= 1'b1;
        end
      end
    end
  end

  // One write per present diagonal walked; one read per read item that passes its checks.
  always_ff @(posedge clk) begin
    if (walking_r && hit) begin
      rank_mem[fill_r[DIAG_W-1:0]] <= walk_diag_r;
    end
    if (ctl.rd_en) begin
      rd_diag_r <= rank_mem[rd_idx];
    end
  end

  assign sts     = '{walking: walking_r, ranked: ranked_r};
  assign total   = total_r;
  assign rd_diag = rd_diag_r;

endmodule

FILE: rtl/core/sparse_csr_to_dia_converter.sv
// Top level of the sparse CSR to DIA converter with its sequencer and output register.
`include "sparse_csr_to_dia_converter_assert.svh"
// The converter takes one item at a time and answers each with exactly one result item.
// An insert that passes its range checks writes the three words of a nonzero into the
// slot memory at address {diagonal, row} in the cycle it is accepted and marks the
// diagonal present; its result then goes through S_RESP into the output register. A
// read looks up the ranked diagonal in the rank table memory, then reads the slot
// memory before S_RESP loads its result; a read that fails its checks answers like an
// insert. A finish walks the 2*MAX_SIZE-1 presence flags one per cycle. A clear sweeps
// every slot of the memory, one per cycle, to drop its valid bit. The same sweep runs
// after reset, and in_stall stays high until it is done. The slot memory is single-port
// and owned by the sequencer; the next item is taken once the current one has handed
// its result to the output register, which holds it while out_stall is high.
// The configuration port is always ready and should only be written while no item is
// in flight.
module sparse_csr_to_dia_converter #(
  parameter int unsigned MAX_SIZE = csr2dia_pkg::MAX_SIZE_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [csr2dia_pkg::CFG_W-1:0]          cfg_matrix_size,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic [csr2dia_pkg::FUNC_W-1:0]         in_func,
  input  logic [csr2dia_pkg::IDX_W-1:0]          in_row,
  input  logic [csr2dia_pkg::IDX_W-1:0]          in_col,
  input  logic [csr2dia_pkg::WORD_W-1:0]         in_value_xx,
  input  logic [csr2dia_pkg::WORD_W-1:0]         in_value_yy,
  input  logic [csr2dia_pkg::WORD_W-1:0]         in_value_zz,
  input  logic [csr2dia_pkg::RANK_W-1:0]         in_diag_rank,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic [csr2dia_pkg::STATUS_W-1:0]       out_status,
  output logic [csr2dia_pkg::COUNT_W-1:0]        out_num_diagonals,
  output logic signed [csr2dia_pkg::OFFSET_W-1:0] out_diag_offset,
  output logic [csr2dia_pkg::WORD_W-1:0]         out_xx,
  output logic [csr2dia_pkg::WORD_W-1:0]         out_yy,
  output logic [csr2dia_pkg::WORD_W-1:0]         out_zz
);
  import csr2dia_pkg::*;

  localparam int unsigned NDIAG  = 2 * MAX_SIZE - 1;
  localparam int unsigned DIAG_W = $clog2(NDIAG);
  localparam int unsigned ROW_W  = $clog2(MAX_SIZE);
  localparam int unsigned ADDR_W = DIAG_W + ROW_W;
  localparam int unsigned DEPTH  = NDIAG << ROW_W;
  localparam int unsigned CNT_W  = $clog2(NDIAG + 1);
  localparam int unsigned WIDE_W = DIAG_W + 7;
  localparam int unsigned SIZE_LIM = (1 << CFG_W) - 1;
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);

  // Largest usable size the 6-bit register can express. Row and column are at most 31,
  // so a size capped at 63 answers every range check exactly as a larger one would.
  localparam logic [CFG_W-1:0] SIZE_CAP =
    (MAX_SIZE > SIZE_LIM) ? CFG_W'(SIZE_LIM) : CFG_W'(MAX_SIZE);

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_CLEAR,
    S_RANK,
    S_RD_RANK,
    S_RESP
  } state_t;

  state_t             state_r;
  logic [ADDR_W-1:0]  sweep_r;
  logic [CFG_W-1:0]   matrix_size_r;
  logic [CFG_W-1:0]   size_eff;
  logic               row_ok;
  logic               col_ok;
  logic               rank_ok;
  func_t              in_func_e;
  logic [DIAG_W-1:0]  ins_diag;
  logic [ROW_W-1:0]   ins_row;
  logic [ROW_W-1:0]   row_r;
  status_t            res_status_r;
  logic [OFFSET_W-1:0] res_offset_r;
  logic               res_hit_r;

  logic                out_valid_r;
  logic [STATUS_W-1:0] out_status_r;
  logic [COUNT_W-1:0]  out_count_r;
  logic [OFFSET_W-1:0] out_offset_r;
  words_t              out_words_r;

  slot_ctl_t          slot_ctl;
  logic [ADDR_W-1:0]  slot_addr;
  words_t             slot_wdata;
  logic               slot_rd_vld;
  words_t             slot_rd_words;

  rank_ctl_t          rank_ctl;
  rank_sts_t          rank_sts;
  logic [DIAG_W-1:0]  rank_rd_idx;
  logic [CNT_W-1:0]   rank_total;
  logic [DIAG_W-1:0]  rank_rd_diag;

  // A size of zero acts as one; anything beyond the largest matrix acts as the largest.
  always_comb begin
    if (matrix_size_r == '0) begin
      size_eff = CFG_W'(1);
    end else if (matrix_size_r > SIZE_CAP) begin
      size_eff = SIZE_CAP;
    end else begin
      size_eff = matrix_size_r;
    end
  end

  assign in_func_e = func_t'(in_func);
  assign row_ok    = CFG_W'(in_row) < size_eff;
  assign col_ok    = CFG_W'(in_col) < size_eff;

  // Diagonal index is col - row shifted so the lowest diagonal sits at zero. Once the
  // range checks pass, both the diagonal and the row fit their narrow indexes.
  assign ins_diag = DIAG_W'(WIDE_W'(in_col) + WIDE_W'(MAX_SIZE - 1) - WIDE_W'(in_row));
  assign ins_row  = ROW_W'(in_row);

  // A read needs a finished ranking and a rank below the diagonal count.
  assign rank_ok     = rank_sts.ranked && (32'(in_diag_rank) < 32'(rank_total));
  assign rank_rd_idx = DIAG_W'(in_diag_rank);

  assign slot_wdata = '{xx: in_value_xx, yy: in_value_yy, zz: in_value_zz};

  // Memory and rank unit commands. Items only enter in idle, so the slot memory sees at
  // most one access per cycle and a write is always settled before the next read.
  always_comb begin
    slot_ctl  = '0;
    slot_addr = sweep_r;
    rank_ctl  = '0;
    case (state_r)
      S_INIT, S_CLEAR: begin
        slot_ctl.wr_en    = 1'b1;
        slot_ctl.wr_valid = 1'b0;
      end
      S_IDLE: begin
        if (in_valid) begin
          case (in_func_e)
            FUNC_CLEAR: begin
              rank_ctl.clr = 1'b1;
            end
            FUNC_INSERT: begin
              if (row_ok && col_ok) begin
                slot_ctl.wr_en    = 1'b1;
                slot_ctl.wr_valid = 1'b1;
                slot_addr         = {ins_diag, ins_row};
                rank_ctl.mark     = 1'b1;
              end
            end
            FUNC_FINISH: begin
              rank_ctl.walk = 1'b1;
            end
            FUNC_READ: begin
              if (rank_ok && row_ok) begin
                rank_ctl.rd_en = 1'b1;
              end
            end
            default: ;
          endcase
        end
      end
      S_RD_RANK: begin
        slot_ctl.rd_en = 1'b1;
        slot_addr      = {rank_rd_diag, row_r};
      end
      default: ;
    endcase
  end

  csr2dia_slot_mem #(
    .MAX_SIZE (MAX_SIZE)
  ) u_slot_mem (
    .clk      (clk),
    .ctl      (slot_ctl),
    .addr     (slot_addr),
    .wr_words (slot_wdata),
    .rd_vld   (slot_rd_vld),
    .rd_words (slot_rd_words)
  );

  csr2dia_rank_unit #(
    .MAX_SIZE (MAX_SIZE)
  ) u_rank_unit (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (rank_ctl),
    .mark_diag (ins_diag),
    .rd_idx    (rank_rd_idx),
    .sts       (rank_sts),
    .total     (rank_total),
    .rd_diag   (rank_rd_diag)
  );

  // Sequencer, configuration register and output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_INIT;
      sweep_r       <= '0;
      matrix_size_r <= SIZE_CAP;
      out_valid_r   <= 1'b0;
    end else begin
      if (cfg_valid) begin
        matrix_size_r <= cfg_matrix_size;
      end
      // A result taken downstream empties the output register unless a new one
      // is loaded in the same cycle.
      if (out_valid_r && !out_stall && state_r != S_RESP) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_INIT: begin
          if (sweep_r == LAST_ADDR) begin
            sweep_r <= '0;
            state_r <= S_IDLE;
          end else begin
            sweep_r <= sweep_r + 1'b1;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            res_offset_r <= '0;
            res_hit_r    <= 1'b0;
            row_r        <= ins_row;
            case (in_func_e)
              FUNC_CLEAR: begin
                res_status_r <= STAT_OK;
                state_r      <= S_CLEAR;
              end
              FUNC_INSERT: begin
                if (row_ok && col_ok) begin
                  res_status_r <= STAT_OK;
                end else begin
                  res_status_r <= STAT_RANGE;
                end
                state_r <= S_RESP;
              end
              FUNC_FINISH: begin
                res_status_r <= STAT_OK;
                state_r      <= S_RANK;
              end
              FUNC_READ: begin
                if (!rank_ok) begin
                  res_status_r <= STAT_ORDER;
                  state_r      <= S_RESP;
                end else if (!row_ok) begin
                  res_status_r <= STAT_RANGE;
                  state_r      <= S_RESP;
                end else begin
                  res_status_r <= STAT_OK;
                  state_r      <= S_RD_RANK;
                end
              end
              default: begin
                res_status_r <= STAT_OK;
                state_r      <= S_RESP;
              end
            endcase
          end
        end
        S_CLEAR: begin
          if (sweep_r == LAST_ADDR) begin
            sweep_r <= '0;
            state_r <= S_RESP;
          end else begin
            sweep_r <= sweep_r + 1'b1;
          end
        end
        S_RANK: begin
          if (!rank_sts.walking) begin
            state_r <= S_RESP;
          end
        end
        S_RD_RANK: begin
          // The slot read issued here lands in the memory's output register next cycle.
          res_offset_r <= OFFSET_W'(WIDE_W'(rank_rd_diag) - WIDE_W'(MAX_SIZE - 1));
          res_hit_r    <= 1'b1;
          state_r      <= S_RESP;
        end
        S_RESP: begin
          if (!out_valid_r || !out_stall) begin
            out_valid_r  <= 1'b1;
            out_status_r <= res_status_r;
            out_count_r  <= COUNT_W'(rank_total);
            out_offset_r <= res_offset_r;
            out_words_r  <= (res_hit_r && slot_rd_vld) ? slot_rd_words : '0;
            state_r      <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign cfg_ready         = 1'b1;
  assign in_stall          = (state_r != S_IDLE);
  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_num_diagonals = out_count_r;
  assign out_diag_offset   = out_offset_r;
  assign out_xx            = out_words_r.xx;
  assign out_yy            = out_words_r.yy;
  assign out_zz            = out_words_r.zz;

  `CSR2DIA_ASSERT_NEVER(a_slot_one_access, slot_ctl.wr_en && slot_ctl.rd_en, "slot conflict")
  `CSR2DIA_ASSERT(a_walk_in_rank, rank_sts.walking |-> state_r == S_RANK, "walk outside finish")
  `CSR2DIA_ASSERT(a_read_ranked, state_r == S_RD_RANK |-> rank_sts.ranked, "slot read unranked")
  `CSR2DIA_ASSERT(a_resp_drains, state_r == S_RESP && !out_stall |=> state_r == S_IDLE, "stuck")

endmodule

FILE: tb/sparse_csr_to_dia_converter_tb.sv
// Self-checking testbench of the CSR to DIA converter: directed and random items against a predictor.
module sparse_csr_to_dia_converter_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import csr2dia_pkg::*;

  localparam int MAX_SIZE     = MAX_SIZE_DEF;
  localparam int NDIAG        = 2 * MAX_SIZE - 1;
  // Once the last result has been taken the converter is back in idle, so a
  // short pause is enough before touching the register.
  localparam int DRAIN_CYCLES = 8;
  localparam int HOLD_CYCLES  = 400;
  localparam int PHASE_ITEMS  = 290;
  // Generous bound: the slowest legal run is dominated by the sweeps after reset
  // and after each clear.
  localparam longint RUN_LIMIT_NS = 64'd10_000_000;

  // How the two sides of the item channels idle in a phase.
  typedef enum int {
    IDLE_RX_HEAVY,  // sender idles at a chance of 8 percent, receiver 54 percent
    IDLE_TX_HEAVY,  // sender idles at a chance of 54 percent, receiver 8 percent
    IDLE_OFF        // neither side idles
  } idle_mode_t;

  typedef struct {
    func_t            func;
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
    words_t           w;
    logic [RANK_W-1:0] rank;
  } item_t;

  typedef struct {
    status_t                     status;
    logic [COUNT_W-1:0]          count;
    logic signed [OFFSET_W-1:0]  offset;
    words_t                      w;
  } result_t;

  logic                       clk;
  logic                       rst_n;
  logic                       cfg_valid;
  logic                       cfg_ready;
  logic [CFG_W-1:0]           cfg_matrix_size;
  logic                       in_valid;
  logic                       in_stall;
  logic [FUNC_W-1:0]          in_func;
  logic [IDX_W-1:0]           in_row;
  logic [IDX_W-1:0]           in_col;
  logic [WORD_W-1:0]          in_value_xx;
  logic [WORD_W-1:0]          in_value_yy;
  logic [WORD_W-1:0]          in_value_zz;
  logic [RANK_W-1:0]          in_diag_rank;
  logic                       out_valid;
  logic                       out_stall;
  logic [STATUS_W-1:0]        out_status;
  logic [COUNT_W-1:0]         out_num_diagonals;
  logic signed [OFFSET_W-1:0] out_diag_offset;
  logic [WORD_W-1:0]          out_xx;
  logic [WORD_W-1:0]          out_yy;
  logic [WORD_W-1:0]          out_zz;

  sparse_csr_to_dia_converter u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_matrix_size   (cfg_matrix_size),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_func           (in_func),
    .in_row            (in_row),
    .in_col            (in_col),
    .in_value_xx       (in_value_xx),
    .in_value_yy       (in_value_yy),
    .in_value_zz       (in_value_zz),
    .in_diag_rank      (in_diag_rank),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_status        (out_status),
    .out_num_diagonals (out_num_diagonals),
    .out_diag_offset   (out_diag_offset),
    .out_xx            (out_xx),
    .out_yy            (out_yy),
    .out_zz            (out_zz)
  );

  // Items waiting to be driven, and results that accepted items must produce.
  item_t   item_queue[$];
  result_t expected_results[$];

  int error_count   = 0;
  int pushed_count  = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  bit in_taken      = 1'b0;

  // Long receiver hold-off, requested by the sequence and counted by the receiver.
  bit hold_req  = 1'b0;
  bit hold_done = 1'b0;
  int hold_left = 0;

  // Shadow of the converter: register, slot store, presence flags and ranking.
  logic [CFG_W-1:0]                  size_reg;
  bit   [NDIAG-1:0][MAX_SIZE-1:0]    slot_vld;
  words_t                            slot_data[NDIAG][MAX_SIZE];
  bit   [NDIAG-1:0]                  diag_present;
  int                                rank_tab[NDIAG];
  int                                diag_total;
  bit                                is_ranked;

  // The stimulus generator keeps its own view of which diagonals hold data,
  // so that reads can aim at ranks that really exist.
  bit [NDIAG-1:0] gen_present = '0;
  int             gen_size    = MAX_SIZE;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #(RUN_LIMIT_NS);
    $display("TEST FAILED");
    $finish;
  end

  // A size of zero acts as one; anything beyond the largest matrix is clipped.
  function automatic int eff_size(input logic [CFG_W-1:0] v);
    if (v == '0) return 1;
    if (int'(v) > MAX_SIZE) return MAX_SIZE;
    return int'(v);
  endfunction

  // Applies one item to the shadow state and returns the result it must give.
  function automatic result_t convert_item(input item_t it);
    result_t r;
    int      sz;
    int      d;
    int      n;
    r.status = STAT_OK;
    r.offset = '0;
    r.w      = '0;
    sz       = eff_size(size_reg);
    case (it.func)
      FUNC_CLEAR: begin
        // The register survives a clear; everything else is emptied.
        slot_vld     = '0;
        diag_present = '0;
        diag_total   = 0;
        is_ranked    = 1'b0;
      end
      FUNC_INSERT: begin
        if (int'(it.row) >= sz || int'(it.col) >= sz) begin
          r.status = STAT_RANGE;
        end else begin
          d = int'(it.col) + MAX_SIZE - 1 - int'(it.row);
          slot_data[d][it.row] = it.w;
          slot_vld[d][it.row]  = 1'b1;
          diag_present[d]      = 1'b1;
          // Any stored insert invalidates the ranking until the next finish.
          is_ranked            = 1'b0;
        end
      end
      FUNC_FINISH: begin
        n = 0;
        for (d = 0; d < NDIAG; d++) begin
          if (diag_present[d]) begin
            rank_tab[n] = d;
            n++;
          end
        end
        diag_total = n;
        is_ranked  = 1'b1;
      end
      default: begin
        // The ordering check wins over the row range check.
        if (!is_ranked || int'(it.rank) >= diag_total || int'(it.rank) >= NDIAG) begin
          r.status = STAT_ORDER;
        end else if (int'(it.row) >= sz) begin
          r.status = STAT_RANGE;
        end else begin
          d        = rank_tab[it.rank];
          r.offset = OFFSET_W'(d - (MAX_SIZE - 1));
          if (slot_vld[d][it.row]) r.w = slot_data[d][it.row];
        end
      end
    endcase
    r.count = COUNT_W'(diag_total);
    return r;
  endfunction

  task automatic report_error(input string msg);
    $display("ERROR at %0t: %s", $realtime, msg);
    error_count++;
  endtask

  task automatic check_result(input result_t got);
    result_t exp;
    if (expected_results.size() == 0) begin
      report_error("result item with no item outstanding");
      return;
    end
    exp = expected_results.pop_front();
    if (got.status !== exp.status)
      report_error($sformatf("status got %0d expected %0d", got.status, exp.status));
    if (got.count !== exp.count)
      report_error($sformatf("num_diagonals got %0d expected %0d", got.count, exp.count));
    if (got.offset !== exp.offset)
      report_error($sformatf("diag_offset got %0d expected %0d", got.offset, exp.offset));
    if (got.w.xx !== exp.w.xx)
      report_error($sformatf("xx got %h expected %h", got.w.xx, exp.w.xx));
    if (got.w.yy !== exp.w.yy)
      report_error($sformatf("yy got %h expected %h", got.w.yy, exp.w.yy));
    if (got.w.zz !== exp.w.zz)
      report_error($sformatf("zz got %h expected %h", got.w.zz, exp.w.zz));
  endtask

  // Monitor: every rising edge it records register writes, predicts accepted
  // items and checks accepted results. After reset, all shadow state changes here.
  always @(posedge clk) begin : monitor
    item_t   it;
    result_t got;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) size_reg = cfg_matrix_size;
      if (in_valid && !in_stall) begin
        it.func = func_t'(in_func);
        it.row  = in_row;
        it.col  = in_col;
        it.w    = '{in_value_xx, in_value_yy, in_value_zz};
        it.rank = in_diag_rank;
        expected_results.push_back(convert_item(it));
      end
      if (out_valid && !out_stall) begin
        got.status = status_t'(out_status);
        got.count  = out_num_diagonals;
        got.offset = out_diag_offset;
        got.w      = '{out_xx, out_yy, out_zz};
        check_result(got);
      end
    end
    in_taken <= rst_n && in_valid && !in_stall;
  end

  // Driver: on the falling edge, once the current item has gone (or none is
  // offered), either idles or presents the next pending item. An offered item
  // is held unchanged until it is taken.
  always @(negedge clk) begin : driver
    item_t nxt;
    if (rst_n && (!in_valid || in_taken)) begin
      if (item_queue.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        nxt = item_queue.pop_front();
        in_valid     <= 1'b1;
        in_func      <= nxt.func;
        in_row       <= nxt.row;
        in_col       <= nxt.col;
        in_value_xx  <= nxt.w.xx;
        in_value_yy  <= nxt.w.yy;
        in_value_zz  <= nxt.w.zz;
        in_diag_rank <= nxt.rank;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, plus one long hold-off that lets the converter
  // fill its output register and push back on the input side.
  always @(negedge clk) begin : receiver
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_req && !hold_done) begin
      out_stall <= 1'b1;
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  function automatic words_t rand_words();
    words_t w;
    w.xx = {$urandom, $urandom};
    w.yy = {$urandom, $urandom};
    w.zz = {$urandom, $urandom};
    return w;
  endfunction

  function automatic item_t rand_item(input func_t f);
    item_t it;
    it.func = f;
    it.row  = IDX_W'($urandom_range(0, 31));
    it.col  = IDX_W'($urandom_range(0, 31));
    it.w    = rand_words();
    it.rank = RANK_W'($urandom_range(0, 63));
    return it;
  endfunction

  function automatic item_t make_item(input func_t f, input int row, input int col,
                                      input words_t w, input int rank);
    item_t it;
    it.func = f;
    it.row  = IDX_W'(row);
    it.col  = IDX_W'(col);
    it.w    = w;
    it.rank = RANK_W'(rank);
    return it;
  endfunction

  // Queues an item and tracks which diagonals it fills for later read targeting.
  task automatic push_item(input item_t it);
    if (it.func == FUNC_INSERT && int'(it.row) < gen_size && int'(it.col) < gen_size)
      gen_present[int'(it.col) + MAX_SIZE - 1 - int'(it.row)] = 1'b1;
    else if (it.func == FUNC_CLEAR)
      gen_present = '0;
    item_queue.push_back(it);
    pushed_count++;
  endtask

  // Writes the size register; only called while nothing is in flight.
  task automatic write_size(input int v);
    @(negedge clk);
    cfg_valid       <= 1'b1;
    cfg_matrix_size <= CFG_W'(v);
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    gen_size = eff_size(CFG_W'(v));
  endtask

  task automatic set_idle(input idle_mode_t mode);
    case (mode)
      IDLE_RX_HEAVY: begin
        send_idle_pct = 8;
        recv_idle_pct = 54;
      end
      IDLE_TX_HEAVY: begin
        send_idle_pct = 54;
        recv_idle_pct = 8;
      end
      default: begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
    endcase
  endtask

  // Waits until every queued item is taken and every result has arrived,
  // then waits out the drain pause so the converter is surely quiet.
  task automatic wait_idle();
    do @(posedge clk); while (item_queue.size() != 0 || in_valid);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Random stimulus: mostly build-and-query sequences (a burst of inserts, a
  // finish, then reads), with occasional clears and fully random noise items.
  task automatic gen_phase(input int n_items);
    item_t          it;
    int             start;
    int             pick;
    int             j;
    int             d;
    int             hit_row[$];
    int             hit_col[$];
    bit [NDIAG-1:0] below;
    start = pushed_count;
    while (pushed_count - start < n_items) begin
      pick = $urandom_range(0, 99);
      if (pick < 75) begin
        hit_row.delete();
        hit_col.delete();
        repeat ($urandom_range(1, 10)) begin
          it = rand_item(FUNC_INSERT);
          // Most inserts land inside the matrix; the rest test the range check.
          if ($urandom_range(0, 9) != 0) begin
            it.row = IDX_W'($urandom_range(0, gen_size - 1));
            it.col = IDX_W'($urandom_range(0, gen_size - 1));
          end
          hit_row.push_back(int'(it.row));
          hit_col.push_back(int'(it.col));
          push_item(it);
        end
        push_item(rand_item(FUNC_FINISH));
        repeat ($urandom_range(1, 8)) begin
          it = rand_item(FUNC_READ);
          if ($urandom_range(0, 1) == 1) begin
            // Aim at a slot just written: its rank is the number of present
            // diagonals with a lower offset.
            j      = $urandom_range(0, hit_row.size() - 1);
            d      = hit_col[j] + MAX_SIZE - 1 - hit_row[j];
            below  = {NDIAG{1'b1}} >> (NDIAG - d);
            it.row = IDX_W'(hit_row[j]);
            it.rank = RANK_W'($countones(gen_present & below));
          end else if ($urandom_range(0, 2) != 0) begin
            it.rank = RANK_W'($urandom_range(0, 7));
          end
          push_item(it);
        end
      end else if (pick < 78) begin
        push_item(rand_item(FUNC_CLEAR));
      end else begin
        push_item(rand_item(func_t'($urandom_range(0, 3))));
      end
    end
  endtask

  initial begin
    int         p;
    int         phase_size[6];
    words_t     ones;
    words_t     zeros;
    words_t     pat_a;
    words_t     pat_b;
    words_t     pat_c;
    phase_size = '{1, 63, 0, 32, 9, 20};
    ones  = '{64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF};
    zeros = '0;
    pat_a = '{64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210, 64'h5555_AAAA_5555_AAAA};
    pat_b = '{64'hDEAD_BEEF_0000_0001, 64'h8000_0000_0000_0000, 64'h0000_0000_0000_0001};
    pat_c = '{64'hA5A5_A5A5_A5A5_A5A5, 64'h3C3C_3C3C_3C3C_3C3C, 64'h0F0F_0F0F_0F0F_0F0F};

    // Every input gets a known value before the first clock edge.
    rst_n           = 1'b0;
    cfg_valid       = 1'b0;
    cfg_matrix_size = '0;
    in_valid        = 1'b0;
    in_func         = '0;
    in_row          = '0;
    in_col          = '0;
    in_value_xx     = '0;
    in_value_yy     = '0;
    in_value_zz     = '0;
    in_diag_rank    = '0;
    out_stall       = 1'b0;

    // Shadow state after reset.
    size_reg     = CFG_W'(MAX_SIZE);
    slot_vld     = '0;
    diag_present = '0;
    diag_total   = 0;
    is_ranked    = 1'b0;

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part at the full size. The converter sweeps its store after
    // reset, and the driver simply waits for in_stall to drop.
    set_idle(IDLE_RX_HEAVY);
    write_size(MAX_SIZE);
    push_item(make_item(FUNC_READ,    0,  0, zeros, 0));   // read before any finish
    push_item(make_item(FUNC_FINISH,  0,  0, zeros, 0));   // finish on an empty store
    push_item(make_item(FUNC_READ,    0,  0, zeros, 0));   // rank beyond a zero count
    push_item(make_item(FUNC_INSERT,  0, 31, ones,  0));   // highest diagonal
    push_item(make_item(FUNC_INSERT, 31,  0, zeros, 0));   // lowest diagonal
    push_item(make_item(FUNC_INSERT,  5,  5, pat_a, 0));
    push_item(make_item(FUNC_INSERT,  5,  5, pat_b, 0));   // same slot again, later wins
    push_item(make_item(FUNC_READ,    5,  0, zeros, 1));   // inserts undid the ranking
    push_item(make_item(FUNC_FINISH,  0,  0, zeros, 0));   // three diagonals
    push_item(make_item(FUNC_READ,   31,  0, zeros, 0));   // offset -31, stored zeros
    push_item(make_item(FUNC_READ,    0,  0, zeros, 0));   // never-written slot
    push_item(make_item(FUNC_READ,    0,  0, zeros, 2));   // offset +31
    push_item(make_item(FUNC_READ,    5,  0, zeros, 1));   // main diagonal, last write
    push_item(make_item(FUNC_READ,    0,  0, zeros, 3));   // rank equal to the count
    push_item(make_item(FUNC_READ,    0,  0, zeros, 63));  // largest rank code
    push_item(make_item(FUNC_INSERT, 31, 31, pat_c, 0));   // insert after finish
    push_item(make_item(FUNC_READ,   31,  0, zeros, 1));   // not ranked, count kept
    push_item(make_item(FUNC_FINISH,  0,  0, zeros, 0));
    wait_idle();

    // Shrink the matrix without clearing: old slots stay reachable only
    // while their row is still inside the new size.
    write_size(4);
    push_item(make_item(FUNC_INSERT,  4,  0, pat_a, 0));   // row outside the matrix
    push_item(make_item(FUNC_INSERT,  0,  4, pat_a, 0));   // column outside the matrix
    push_item(make_item(FUNC_READ,    5,  0, zeros, 1));   // stored row now out of range
    push_item(make_item(FUNC_READ,    3,  0, zeros, 1));   // in range, never written
    push_item(make_item(FUNC_CLEAR,   0,  0, zeros, 0));
    push_item(make_item(FUNC_READ,    0,  0, zeros, 0));   // nothing ranked after clear
    wait_idle();

    // Random phases: register settings include the extremes and the codes
    // outside the legal range, and the idling pattern rotates.
    for (p = 0; p < 6; p++) begin
      write_size(phase_size[p]);
      set_idle(idle_mode_t'(p % 3));
      gen_phase(PHASE_ITEMS);
      if (p == 2) begin
        // The sender never idles here, so a long hold-off backs up the input.
        while (item_queue.size() > PHASE_ITEMS - 80) @(posedge clk);
        hold_req = 1'b1;
      end
      wait_idle();
    end

    if (error_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

FILE: sparse_csr_to_dia_converter.f
+incdir+rtl/core
rtl/core/csr2dia_pkg.sv
rtl/core/csr2dia_slot_mem.sv
rtl/core/csr2dia_rank_unit.sv
rtl/core/sparse_csr_to_dia_converter.sv
tb/sparse_csr_to_dia_converter_tb.sv
